### rtl/htfd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-8 byte update for the humidity and
// temperature frame decoder. No dependencies.
package htfd_pkg;

  // CRC-8 as used by the sensor: poly x^8+x^5+x^4+1, init 0xFF, MSB first
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions inside a six-byte reply
  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  // Scaling constants, all in hundredths
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;

  // Frame status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TEMP_CRC = 2'd1,
    STAT_HUM_CRC  = 2'd2
  } htfd_status_t;

  // Run one byte through the CRC register, eight shifts MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/htfd_scale.sv
`timescale 1ns / 1ps
// Converts raw temperature and humidity words to hundredths of a degree and
// of a percent. Depends on htfd_pkg.
module htfd_scale import htfd_pkg::*; (
  input  logic [15:0]        temp_raw,
  input  logic [15:0]        hum_raw,
  output logic signed [14:0] temp_centi,
  output logic [13:0]        hum_centi
);

  logic [30:0] temp_prod;
  logic [29:0] hum_prod;
  logic [31:0] temp_sum;
  logic [31:0] hum_sum;
  logic [14:0] temp_quot;
  logic [13:0] hum_quot;
  logic [15:0] temp_diff;

  // Scale by the span: 16x15 and 16x14 bit products
  assign temp_prod = 31'(temp_raw) * 31'(TEMP_SPAN);
  assign hum_prod  = 30'(hum_raw) * 30'(HUM_SPAN);

  // Divide by 65535: floor(x / (2^16-1)) = (x + (x >> 16) + 1) >> 16, exact below 2^32 - 1
  assign temp_sum  = 32'(temp_prod) + 32'(temp_prod[30:16]) + 32'd1;
  assign hum_sum   = 32'(hum_prod) + 32'(hum_prod[29:16]) + 32'd1;
  assign temp_quot = temp_sum[30:16];
  assign hum_quot  = hum_sum[29:16];

  // Shift temperature down by 45 degrees
  assign temp_diff  = 16'(temp_quot) - TEMP_OFFSET;
  assign temp_centi = temp_diff[14:0];
  assign hum_centi  = hum_quot;

endmodule

### rtl/humidity_temp_frame_decoder.sv
`timescale 1ns / 1ps
// Top level of the humidity and temperature frame decoder: byte sequencing,
// CRC checking and the result register. Depends on htfd_pkg and htfd_scale.

// The block takes one reply byte per cycle on the input stream, in the order
// temperature high, low, CRC, humidity high, low, CRC, and returns one result
// in the cycle after the sixth byte is taken: both raw words, temperature in
// hundredths of a degree C, humidity in hundredths of a percent, and a status
// on out_tuser (0 ok, 1 temperature CRC bad, 2 humidity CRC bad; temperature
// wins when both are bad). Values are computed even when a CRC is bad.
// in_tuser high marks a byte as the first of a new frame and restarts the
// sequence. The single result register sets the pace, so bytes keep flowing
// every cycle while out_tready is high or the register is empty, and a held
// result stalls the input.
module humidity_temp_frame_decoder import htfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] temp_raw, [31:16] hum_raw,
                                  // [46:32] temp_centi, [60:47] hum_centi, [63:61] zero
  output logic [1:0]  out_tuser   // [1:0] frame_status
);

  logic [2:0]         pos_r, pos_nxt, pos_cur;
  logic [7:0]         crc_r, crc_nxt, crc_run;
  logic [15:0]        temp_word_r, temp_word_nxt;
  logic [15:0]        hum_word_r, hum_word_nxt;
  logic               temp_bad_r, temp_bad_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [60:0]        out_data_r, out_data_nxt;
  htfd_status_t       out_stat_r, out_stat_nxt;
  logic               in_fire;
  logic               frame_done;
  logic signed [14:0] temp_centi;
  logic [13:0]        hum_centi;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;

  // Resync on frame start or an out-of-range position
  assign pos_cur = (in_tuser || pos_r > POS_HUM_CRC) ? POS_TEMP_HI : pos_r;
  assign crc_run = crc8_byte(crc_r, in_tdata);

  htfd_scale u_scale (
    .temp_raw  (temp_word_r),
    .hum_raw   (hum_word_r),
    .temp_centi(temp_centi),
    .hum_centi (hum_centi)
  );

  // Advance the frame sequence on each input transfer
  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    hum_word_nxt  = hum_word_r;
    temp_bad_nxt  = temp_bad_r;
    frame_done    = 1'b0;
    if (in_fire) begin
      pos_nxt = pos_cur + 3'd1;
      unique case (pos_cur)
        POS_TEMP_HI: begin
          temp_word_nxt = {in_tdata, 8'h00};
          crc_nxt       = crc8_byte(CRC_INIT, in_tdata);
        end
        POS_TEMP_LO: begin
          temp_word_nxt = {temp_word_r[15:8], in_tdata};
          crc_nxt       = crc_run;
        end
        POS_TEMP_CRC: begin
          temp_bad_nxt = (crc_r != in_tdata);
          crc_nxt      = CRC_INIT;
        end
        POS_HUM_HI: begin
          hum_word_nxt = {in_tdata, 8'h00};
          crc_nxt      = crc8_byte(CRC_INIT, in_tdata);
        end
        POS_HUM_LO: begin
          hum_word_nxt = {hum_word_r[15:8], in_tdata};
          crc_nxt      = crc_run;
        end
        default: begin
          frame_done = 1'b1;
          crc_nxt    = CRC_INIT;
          pos_nxt    = POS_TEMP_HI;
        end
      endcase
    end
  end

  // Load the result register on the last byte, drop it once transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (frame_done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {hum_centi, temp_centi, hum_word_r, temp_word_r};
      priority if (temp_bad_r)         out_stat_nxt = STAT_TEMP_CRC;
      else if (crc_r != in_tdata)      out_stat_nxt = STAT_HUM_CRC;
      else                             out_stat_nxt = STAT_OK;
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_TEMP_HI;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    temp_word_r <= temp_word_nxt;
    hum_word_r  <= hum_word_nxt;
    temp_bad_r  <= temp_bad_nxt;
    out_data_r  <= out_data_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};
  assign out_tuser  = out_stat_r;

  // Position never leaves the six-byte frame
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_HUM_CRC)
    else $error("byte position out of range");

  // CRC register is back at its initial value at each word start
  a_crc_init: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == POS_TEMP_HI || pos_r == POS_HUM_HI) |-> crc_r == CRC_INIT)
    else $error("CRC not restarted at word start");

  // A sixth byte always produces a result in the next cycle
  a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> out_valid_r)
    else $error("finished frame gave no result");

  // Bytes before the sixth never create a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !frame_done) |=> !out_valid_r)
    else $error("result appeared without a finished frame");

  // Status is never the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_stat_r == STAT_OK || out_stat_r == STAT_TEMP_CRC ||
                     out_stat_r == STAT_HUM_CRC))
    else $error("invalid frame status");

endmodule
